>>> rtl/nfaec_pkg.sv
// ----------------------------------------------------------------------------
// nfaec_pkg
// Shared codes and types for the NFA epsilon-closure runner.
// ----------------------------------------------------------------------------
package nfaec_pkg;

  localparam int REQ_W  = 2;
  localparam int IDX_W  = 4;
  localparam int SYM_W  = 4;
  localparam int MASK_W = 16;

  localparam logic [REQ_W-1:0] REQ_LINK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FEED    = 2'd2;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LRD   = 8'b0000_0100,
    ST_LWR   = 8'b0000_1000,
    ST_SUCC  = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_CLOS  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic gate;
  } acc_ctrl_t;

endpackage

>>> rtl/nfaec_trans_mem.sv
// ----------------------------------------------------------------------------
// nfaec_trans_mem
// Symbol transition table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfaec_trans_mem #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/nfaec_or_unit.sv
// ----------------------------------------------------------------------------
// nfaec_or_unit
// Shared gated OR accumulator for successor and closure passes.
// ----------------------------------------------------------------------------
module nfaec_or_unit
  import nfaec_pkg::*;
#(
  parameter int W = 16
) (
  input  logic      clk,
  input  acc_ctrl_t ctrl,
  input  logic [W-1:0] operand,
  output logic [W-1:0] acc,
  output logic [W-1:0] acc_next,
  output logic         grew
);

  logic take;

  assign take     = ctrl.en && ctrl.gate;
  assign acc_next = take ? (acc | operand) : acc;
  assign grew     = take && ((operand & ~acc) != '0);

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

>>> rtl/nfa_epsilon_closure_runner_core.sv
// ----------------------------------------------------------------------------
// nfa_epsilon_closure_runner_core
// NFA runner with bitmask state set, link tables and epsilon closure.
// ----------------------------------------------------------------------------
// Input words on s_*: tuser carries the request kind, tdata the link fields.
// Each word yields one result word on m_*: tuser {in_end, ok}, tdata the
// active set. Registers start_mask (0x0) and end_mask (0x4) sit on the APB
// port; pready is always high.
// After reset a clearing pass writes zero to every entry of the transition
// memory, 2**(clog2(NUM_STATES)+clog2(NUM_SYMBOLS)) entries (256 by default);
// s_tready stays low meanwhile, register writes are still taken.
// Steps per word, from acceptance to result:
//   epsilon link, restart, rejected link or feed: straight to the result
//   symbol link: read-modify-write of the transition memory, then the result
//   feed: NUM_STATES successor reads through the one memory port; when
//   successors were found, the closure then sweeps one state per cycle
//   through the shared OR unit until NUM_STATES steps in a row add nothing;
//   then the result is issued.
// One word is in work at a time; the next is accepted once the result is
// in the output register. A stalled receiver holds the result there and
// the block waits before issuing the following result.
// ----------------------------------------------------------------------------
module nfa_epsilon_closure_runner_core
  import nfaec_pkg::*;
#(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // from_state[3:0], to_state[7:4], symbol[11:8], is_epsilon[12]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // active_mask[15:0]
  output logic [1:0]  m_tuser,   // ok[0], in_end[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int YW = $clog2(NUM_SYMBOLS);
  localparam int AW = SW + YW;
  localparam int NS = NUM_STATES;
  localparam logic [SW-1:0] LAST = SW'(NUM_STATES - 1);

  state_t state;

  logic [REQ_W-1:0] req;
  logic [IDX_W-1:0] from_f;
  logic [IDX_W-1:0] to_f;
  logic [SYM_W-1:0] sym_f;
  logic             eps_f;
  logic [7:0]       from_w;
  logic [11:0]      sym_w;
  logic [SW-1:0]    from_idx;
  logic [YW-1:0]    sym_idx;
  logic             from_ok;
  logic             to_ok;
  logic             sym_ok;
  logic [NS-1:0]    to_bit;
  logic             accept;

  logic [MASK_W-1:0] start_r;
  logic [MASK_W-1:0] end_r;
  logic [NS-1:0]     start_ns;
  logic [MASK_W-1:0] act16;

  logic [AW-1:0] addr;
  logic [NS-1:0] bit_r;
  logic          ok_r;
  logic [SW-1:0] cnt;
  logic [SW-1:0] quiet;
  logic          pend;
  logic [SW-1:0] pidx;
  logic [AW-1:0] clr_cnt;
  logic [NS-1:0] active_set;
  logic [NS-1:0] eps_tab [NS];

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [NS-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [NS-1:0] mem_rdata;

  acc_ctrl_t     acc_ctrl;
  logic [NS-1:0] acc_op;
  logic [NS-1:0] acc;
  logic [NS-1:0] acc_next;
  logic          grew;
  logic          clos_done;

  assign req    = s_tuser[1:0];
  assign from_f = s_tdata[3:0];
  assign to_f   = s_tdata[7:4];
  assign sym_f  = s_tdata[11:8];
  assign eps_f  = s_tdata[12];

  assign from_w   = {4'd0, from_f};
  assign sym_w    = {8'd0, sym_f};
  assign from_idx = from_w[SW-1:0];
  assign sym_idx  = sym_w[YW-1:0];
  assign from_ok  = int'(from_f) < NUM_STATES;
  assign to_ok    = int'(to_f) < NUM_STATES;
  assign sym_ok   = int'(sym_f) < NUM_SYMBOLS;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      to_bit[i] = (int'(to_f) == i);
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_start
    if (g < MASK_W) begin : g_in
      assign start_ns[g] = start_r[g];
    end else begin : g_out
      assign start_ns[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < MASK_W; g++) begin : g_act
    if (g < NS) begin : g_in
      assign act16[g] = active_set[g];
    end else begin : g_out
      assign act16[g] = 1'b0;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_r <= '0;
      end_r   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        CFG_START: start_r <= pwdata[MASK_W-1:0];
        CFG_END:   end_r   <= pwdata[MASK_W-1:0];
        default:   start_r <= start_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_START: prdata = {16'd0, start_r};
      CFG_END:   prdata = {16'd0, end_r};
      default:   prdata = '0;
    endcase
  end

  // transition memory
  assign mem_we    = (state == ST_CLEAR) || (state == ST_LWR);
  assign mem_waddr = (state == ST_CLEAR) ? clr_cnt : addr;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : (mem_rdata | bit_r);
  assign mem_raddr = (state == ST_LRD) ? addr : {cnt, addr[YW-1:0]};

  nfaec_trans_mem #(
    .AW(AW),
    .DW(NS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // shared OR unit
  always_comb begin
    acc_ctrl.clr  = accept;
    acc_ctrl.en   = 1'b0;
    acc_ctrl.gate = 1'b0;
    acc_op        = mem_rdata;
    if ((state == ST_SUCC) || (state == ST_DRAIN)) begin
      acc_ctrl.en   = pend;
      acc_ctrl.gate = active_set[pidx];
    end else if (state == ST_CLOS) begin
      acc_ctrl.en   = 1'b1;
      acc_ctrl.gate = acc[cnt];
      acc_op        = eps_tab[cnt];
    end
  end

  nfaec_or_unit #(
    .W(NS)
  ) u_or (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .operand (acc_op),
    .acc     (acc),
    .acc_next(acc_next),
    .grew    (grew)
  );

  assign clos_done = (state == ST_CLOS) && !grew && (quiet == LAST);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      active_set <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        eps_tab[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            addr  <= {from_idx, sym_idx};
            bit_r <= to_bit;
            unique case (req)
              REQ_LINK: begin
                ok_r  <= 1'b1;
                state <= (from_ok && to_ok && !eps_f && sym_ok) ? ST_LRD : ST_DONE;
                if (from_ok && to_ok && eps_f) begin
                  eps_tab[from_idx] <= eps_tab[from_idx] | to_bit;
                end
              end
              REQ_RESTART: begin
                ok_r       <= 1'b1;
                active_set <= start_ns;
                state      <= ST_DONE;
              end
              REQ_FEED: begin
                ok_r  <= sym_ok;
                cnt   <= '0;
                pend  <= 1'b0;
                state <= sym_ok ? ST_SUCC : ST_DONE;
              end
              default: begin
                ok_r  <= 1'b1;
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_LRD: state <= ST_LWR;
        ST_LWR: state <= ST_DONE;
        ST_SUCC: begin
          pend <= 1'b1;
          pidx <= cnt;
          if (cnt == LAST) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          pend <= 1'b0;
          if (acc_next == '0) begin
            ok_r  <= 1'b0;
            state <= ST_DONE;
          end else begin
            cnt   <= '0;
            quiet <= '0;
            state <= ST_CLOS;
          end
        end
        ST_CLOS: begin
          cnt   <= (cnt == LAST) ? '0 : cnt + 1'b1;
          quiet <= grew ? '0 : quiet + 1'b1;
          if (clos_done) begin
            active_set <= acc_next;
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {(act16 & end_r) != '0, ok_r};
            m_tdata  <= act16;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_feed_nonempty: assert property (@(posedge clk) disable iff (rst)
    clos_done |=> (active_set != '0))
    else $error("closure produced an empty active set");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result word issued outside completion");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (pend && (pidx == LAST)))
    else $error("successor scan drained before last state");

endmodule
